[rtl/lage_pkg.sv]
// ----------------------------------------------------------------------------
// lage_pkg: shared types and constants of the life automaton grid engine
// field widths, command and register codes, sequencer states, cell rule
// ----------------------------------------------------------------------------
package lage_pkg;

  // grid size default (cells per row and rows)
  localparam int MAX_SIDE_DEF = 64;

  // field widths
  localparam int MODE_W      = 2;
  localparam int ROW_W       = 6;
  localparam int COL_W       = 6;
  localparam int GRID_SIDE_W = 7;
  localparam int GEN_COUNT_W = 16;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 8;

  // register reset values
  localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RST = GRID_SIDE_W'(64);
  localparam logic [GEN_COUNT_W-1:0] GEN_COUNT_RST = GEN_COUNT_W'(1);

  // b3/s23 rule thresholds
  localparam logic [3:0] SURVIVE_MIN = 4'd2;
  localparam logic [3:0] SURVIVE_MAX = 4'd3;
  localparam logic [3:0] BIRTH_CNT   = 4'd3;

  typedef enum logic [MODE_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GRID_SIDE = 1'b0,
    REG_GEN_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_WB,
    ST_GEN_START,
    ST_GEN_PRIME,
    ST_GEN_ROW,
    ST_RESP
  } state_t;

  // next value of one cell from its value and its live neighbor count
  function automatic logic next_cell(input logic alive, input logic [3:0] cnt);
    logic res;
    if (alive) begin
      res = (cnt >= SURVIVE_MIN) && (cnt <= SURVIVE_MAX);
    end else begin
      res = (cnt == BIRTH_CNT);
    end
    return res;
  endfunction

endpackage

[rtl/lage_row_mem.sv]
// ----------------------------------------------------------------------------
// lage_row_mem: grid storage, one row of cells per word
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module lage_row_mem #(
  parameter int MAX_SIDE = lage_pkg::MAX_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(MAX_SIDE)-1:0] waddr,
  input  logic [MAX_SIDE-1:0]         wdata,
  input  logic                        re,
  input  logic [$clog2(MAX_SIDE)-1:0] raddr,
  output logic [MAX_SIDE-1:0]         rdata
);

  logic [MAX_SIDE-1:0] mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/lage_row_rule.sv]
// ----------------------------------------------------------------------------
// lage_row_rule: next generation of one row
// counts neighbors from the rows above, at and below, applies b3/s23
// ----------------------------------------------------------------------------
module lage_row_rule #(
  parameter int MAX_SIDE = lage_pkg::MAX_SIDE_DEF
) (
  input  logic [MAX_SIDE-1:0] up,
  input  logic [MAX_SIDE-1:0] mid,
  input  logic [MAX_SIDE-1:0] below,
  input  logic [MAX_SIDE-1:0] mask,
  output logic [MAX_SIDE-1:0] new_row,
  output logic                changed
);

  // zero padding on both ends: no wrap at the grid edge
  logic [MAX_SIDE+1:0] up_p;
  logic [MAX_SIDE+1:0] mid_p;
  logic [MAX_SIDE+1:0] below_p;
  logic [3:0]          cnt [MAX_SIDE];

  assign up_p    = {1'b0, up, 1'b0};
  assign mid_p   = {1'b0, mid, 1'b0};
  assign below_p = {1'b0, below, 1'b0};

  always_comb begin
    for (int c = 0; c < MAX_SIDE; c++) begin
      cnt[c] = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
             + 4'(mid_p[c]) + 4'(mid_p[c+2])
             + 4'(below_p[c]) + 4'(below_p[c+1]) + 4'(below_p[c+2]);
      new_row[c] = mask[c] & lage_pkg::next_cell(mid[c], cnt[c]);
    end
  end

  assign changed = |((new_row ^ mid) & mask);

endmodule

[rtl/life_automaton_grid_engine.sv]
// ----------------------------------------------------------------------------
// life_automaton_grid_engine: bounded game of life grid (b3/s23)
// cell write, cell read and multi-generation runs over a row-wide memory
// ----------------------------------------------------------------------------
//
//  channel | ports                       | fields (lowest bit first)
//  --------+-----------------------------+-------------------------------------
//  input   | in_tvalid/in_tready         | tuser: mode; tdata: row, column,
//          | in_tdata[15:0], in_tuser    |   cell_in, zero fill
//  result  | out_tvalid/out_tready       | tdata: cell_out, zero fill;
//          | out_tdata[7:0], out_tuser   |   tuser: done_kind
//  config  | cfg_we, cfg_addr, cfg_wdata | 0 grid_side, 1 generation_count
//
//  steps: a cell write or read goes through a row read, a row write-back or
//    bit pick, and a result load; a run walks the active side S with one
//    row read and one row write per cycle on the row memory in each
//    generation, and stops early once a generation leaves the grid unchanged
//  reset: a clearing pass writes a zero row to each of the MAX_SIDE rows; no
//    input transfer is taken during it, config writes are
//  stalls: one result register; the next input is taken while a result
//    waits, its own result waits in the response state for the register
//
module life_automaton_grid_engine #(
  parameter int MAX_SIDE = lage_pkg::MAX_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input: tdata = row[5:0], column[11:6], cell_in[12], zeros[15:13]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lage_pkg::IN_DATA_W-1:0]    in_tdata,
  // input: tuser = mode[1:0]
  input  logic [lage_pkg::MODE_W-1:0]       in_tuser,
  // result: tdata = cell_out[0], zeros[7:1]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lage_pkg::OUT_DATA_W-1:0]   out_tdata,
  // result: tuser = done_kind[1:0]
  output logic [lage_pkg::MODE_W-1:0]       out_tuser,
  // config write port
  input  logic                              cfg_we,
  input  logic [lage_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lage_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int RW = $clog2(MAX_SIDE);     // row / column index width
  localparam int SW = $clog2(MAX_SIDE + 1); // active side width

  // state and config
  lage_pkg::state_t                     state_r, state_nxt;
  logic [lage_pkg::GRID_SIDE_W-1:0]     grid_side_r;
  logic [lage_pkg::GEN_COUNT_W-1:0]     gen_count_r;

  // command context
  lage_pkg::cmd_t                       cmd_r, cmd_nxt;
  logic [RW-1:0]                        row_r, row_nxt;
  logic [RW-1:0]                        col_r, col_nxt;
  logic                                 wr_val_r, wr_val_nxt;
  logic                                 res_cell_r, res_cell_nxt;
  logic [RW-1:0]                        clr_cnt_r, clr_cnt_nxt;

  // run context
  logic [SW-1:0]                        side_r, side_nxt;
  logic [MAX_SIDE-1:0]                  mask_r, mask_nxt;
  logic [lage_pkg::GEN_COUNT_W-1:0]     gens_left_r, gens_left_nxt;
  logic [RW-1:0]                        row_k_r, row_k_nxt;
  logic                                 chg_r, chg_nxt;
  logic [MAX_SIDE-1:0]                  up_r, up_nxt;
  logic [MAX_SIDE-1:0]                  mid_r, mid_nxt;
  logic [MAX_SIDE-1:0]                  mid_raw_r, mid_raw_nxt;

  // result register
  logic                                 out_tvalid_r, out_tvalid_nxt;
  logic                                 out_cell_r, out_cell_nxt;
  logic [lage_pkg::MODE_W-1:0]          out_kind_r, out_kind_nxt;

  // memory ports
  logic                                 mem_we, mem_re;
  logic [RW-1:0]                        mem_waddr, mem_raddr;
  logic [MAX_SIDE-1:0]                  mem_wdata, mem_rdata;

  // row update
  logic [MAX_SIDE-1:0]                  below;
  logic [MAX_SIDE-1:0]                  new_row;
  logic                                 row_chg;
  logic                                 has_below;

  // decoded input fields
  logic [lage_pkg::ROW_W-1:0]           in_row;
  logic [lage_pkg::COL_W-1:0]           in_col;
  logic                                 in_cell;
  logic                                 in_inside;
  logic [SW-1:0]                        side_act;
  logic                                 in_xfer;
  logic                                 load_ok;

  assign in_row  = in_tdata[lage_pkg::ROW_W-1:0];
  assign in_col  = in_tdata[lage_pkg::ROW_W +: lage_pkg::COL_W];
  assign in_cell = in_tdata[lage_pkg::ROW_W + lage_pkg::COL_W];

  // addresses beyond the storage are ignored on write, read back as dead
  assign in_inside = (32'(in_row) < MAX_SIDE) && (32'(in_col) < MAX_SIDE);

  // side saturates at the storage size
  assign side_act = (32'(grid_side_r) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(grid_side_r);

  assign in_tready = (state_r == lage_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign load_ok   = !out_tvalid_r || out_tready;

  // below row exists while row k+1 is inside the active square
  assign has_below = (32'(row_k_r) + 32'd1) < 32'(side_r);
  assign below     = has_below ? (mem_rdata & mask_r) : '0;

  lage_row_mem #(
    .MAX_SIDE (MAX_SIDE)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lage_row_rule #(
    .MAX_SIDE (MAX_SIDE)
  ) u_rule (
    .up      (up_r),
    .mid     (mid_r),
    .below   (below),
    .mask    (mask_r),
    .new_row (new_row),
    .changed (row_chg)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= lage_pkg::GRID_SIDE_RST;
      gen_count_r <= lage_pkg::GEN_COUNT_RST;
    end else if (cfg_we) begin
      case (lage_pkg::cfg_reg_t'(cfg_addr))
        lage_pkg::REG_GRID_SIDE: grid_side_r <= cfg_wdata[lage_pkg::GRID_SIDE_W-1:0];
        lage_pkg::REG_GEN_COUNT: gen_count_r <= cfg_wdata[lage_pkg::GEN_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lage_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload and context
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    wr_val_r    <= wr_val_nxt;
    res_cell_r  <= res_cell_nxt;
    side_r      <= side_nxt;
    mask_r      <= mask_nxt;
    gens_left_r <= gens_left_nxt;
    row_k_r     <= row_k_nxt;
    chg_r       <= chg_nxt;
    up_r        <= up_nxt;
    mid_r       <= mid_nxt;
    mid_raw_r   <= mid_raw_nxt;
    out_cell_r  <= out_cell_nxt;
    out_kind_r  <= out_kind_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cmd_nxt        = cmd_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    wr_val_nxt     = wr_val_r;
    res_cell_nxt   = res_cell_r;
    side_nxt       = side_r;
    mask_nxt       = mask_r;
    gens_left_nxt  = gens_left_r;
    row_k_nxt      = row_k_r;
    chg_nxt        = chg_r;
    up_nxt         = up_r;
    mid_nxt        = mid_r;
    mid_raw_nxt    = mid_raw_r;
    out_cell_nxt   = out_cell_r;
    out_kind_nxt   = out_kind_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mem_we         = 1'b0;
    mem_waddr      = row_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = row_r;

    case (state_r)
      // sweep zero rows through the memory after reset
      lage_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + RW'(1);
        if (32'(clr_cnt_r) == MAX_SIDE - 1) begin
          state_nxt = lage_pkg::ST_IDLE;
        end
      end

      lage_pkg::ST_IDLE: begin
        if (in_xfer) begin
          row_nxt      = RW'(in_row);
          col_nxt      = RW'(in_col);
          wr_val_nxt   = in_cell;
          res_cell_nxt = 1'b0;
          case (in_tuser)
            lage_pkg::CMD_WRITE: cmd_nxt = lage_pkg::CMD_WRITE;
            lage_pkg::CMD_RUN:   cmd_nxt = lage_pkg::CMD_RUN;
            default:             cmd_nxt = lage_pkg::CMD_READ;
          endcase
          if (in_tuser == lage_pkg::CMD_RUN) begin
            side_nxt      = side_act;
            gens_left_nxt = gen_count_r;
            for (int c = 0; c < MAX_SIDE; c++) begin
              mask_nxt[c] = (c < 32'(side_act));
            end
            // no generations or no active cells: nothing to do
            if (gen_count_r == '0 || side_act == '0) begin
              state_nxt = lage_pkg::ST_RESP;
            end else begin
              state_nxt = lage_pkg::ST_GEN_START;
            end
          end else if (in_inside) begin
            // fetch the row holding the cell
            mem_re    = 1'b1;
            mem_raddr = RW'(in_row);
            state_nxt = lage_pkg::ST_CELL_WB;
          end else begin
            state_nxt = lage_pkg::ST_RESP;
          end
        end
      end

      // row data is back: patch and write it, or pick the bit
      lage_pkg::ST_CELL_WB: begin
        if (cmd_r == lage_pkg::CMD_WRITE) begin
          mem_we           = 1'b1;
          mem_waddr        = row_r;
          mem_wdata        = mem_rdata;
          mem_wdata[col_r] = wr_val_r;
        end else begin
          res_cell_nxt = mem_rdata[col_r];
        end
        state_nxt = lage_pkg::ST_RESP;
      end

      lage_pkg::ST_GEN_START: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        row_k_nxt = '0;
        chg_nxt   = 1'b0;
        state_nxt = lage_pkg::ST_GEN_PRIME;
      end

      // row 0 arrives: fill the window, fetch row 1
      lage_pkg::ST_GEN_PRIME: begin
        up_nxt      = '0;
        mid_nxt     = mem_rdata & mask_r;
        mid_raw_nxt = mem_rdata;
        if (32'(side_r) > 1) begin
          mem_re    = 1'b1;
          mem_raddr = RW'(1);
        end
        state_nxt = lage_pkg::ST_GEN_ROW;
      end

      // row k+1 arrives: write new row k in place, slide the window.
      // row k-1 is already held, so the in-place write is safe
      lage_pkg::ST_GEN_ROW: begin
        mem_we      = 1'b1;
        mem_waddr   = row_k_r;
        mem_wdata   = (new_row & mask_r) | (mid_raw_r & ~mask_r);
        if ((32'(row_k_r) + 32'd2) < 32'(side_r)) begin
          mem_re    = 1'b1;
          mem_raddr = RW'(32'(row_k_r) + 32'd2);
        end
        up_nxt      = mid_r;
        mid_nxt     = below;
        mid_raw_nxt = mem_rdata;
        chg_nxt     = chg_r | row_chg;
        row_k_nxt   = row_k_r + RW'(1);
        if (!has_below) begin
          // end of a generation; a stable grid ends the run early
          if ((chg_r || row_chg) && gens_left_r > lage_pkg::GEN_COUNT_W'(1)) begin
            gens_left_nxt = gens_left_r - lage_pkg::GEN_COUNT_W'(1);
            state_nxt     = lage_pkg::ST_GEN_START;
          end else begin
            state_nxt = lage_pkg::ST_RESP;
          end
        end
      end

      // hand the result to the output register once it is free
      lage_pkg::ST_RESP: begin
        if (load_ok) begin
          out_tvalid_nxt = 1'b1;
          out_cell_nxt   = res_cell_r;
          out_kind_nxt   = cmd_r;
          state_nxt      = lage_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lage_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(lage_pkg::OUT_DATA_W-1){1'b0}}, out_cell_r};
  assign out_tuser  = out_kind_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a row update never reads the row it writes back
  a_no_rw_same_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lage_pkg::ST_GEN_ROW && mem_re) |-> (mem_raddr != mem_waddr))
    else $error("row read collides with row write-back");

  // the row walk stays inside the active square
  a_row_in_side: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lage_pkg::ST_GEN_ROW) |-> (32'(row_k_r) < 32'(side_r)))
    else $error("row index beyond active side");

  // a new result appears only out of the response state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !$past(out_tvalid_r) && $past(rst_n)) |->
      ($past(state_r) == lage_pkg::ST_RESP))
    else $error("result loaded outside response state");

  // an accepted command always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != lage_pkg::ST_IDLE))
    else $error("accepted command left no trace");

endmodule

[test/life_automaton_grid_engine_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_automaton_grid_engine_tb: self-checking bench for the game of life grid
// drives cell writes, cell reads and generation runs over the input stream,
// mirrors the grid in a local b3/s23 model and checks every result transfer
// ----------------------------------------------------------------------------
module life_automaton_grid_engine_tb;

  localparam int CLK_HALF      = 6;
  localparam int SIDE_LIMIT    = lage_pkg::MAX_SIDE_DEF;
  localparam int GRID_CELLS    = SIDE_LIMIT * SIDE_LIMIT;
  // quiet cycles after the last result before a register write or the end
  localparam int SETTLE_CYCLES = 8;
  // a run that goes through a full 65535 generation count on a tiny grid
  // must still fit between two transfers
  localparam int STALL_LIMIT   = 400000;
  // long receiver hold-off, long enough to back the block up to its input
  localparam int HOLD_OFF_LEN  = 250;

  // b3/s23 neighbor thresholds
  localparam int LIVE_MIN_NEIGHBORS = 2;
  localparam int LIVE_MAX_NEIGHBORS = 3;
  localparam int BIRTH_NEIGHBORS    = 3;

  // mode 3 has the high mode bit set and is decoded as a read
  localparam logic [lage_pkg::MODE_W-1:0] CMD_READ_HIGH = 2'd3;

  typedef struct {
    logic           cell_val;
    lage_pkg::cmd_t kind;
  } cell_answer_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [lage_pkg::IN_DATA_W-1:0]  in_tdata  = '0;
  logic [lage_pkg::MODE_W-1:0]     in_tuser  = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lage_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [lage_pkg::MODE_W-1:0]     out_tuser;
  logic                            cfg_we    = 1'b0;
  logic [lage_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [lage_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // local copy of the grid and of the two registers
  bit                               life_grid [GRID_CELLS];
  bit                               life_next [GRID_CELLS];
  logic [lage_pkg::GRID_SIDE_W-1:0] side_reg = lage_pkg::GRID_SIDE_RST;
  logic [lage_pkg::GEN_COUNT_W-1:0] gens_reg = lage_pkg::GEN_COUNT_RST;

  // one answer per accepted command, oldest first
  cell_answer_t pending_answers [$];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_request   = 0;
  int mismatch_count = 0;
  int write_count    = 0;
  int read_count     = 0;
  int high_read_count = 0;
  int run_count      = 0;
  int setting_count  = 0;

  always #CLK_HALF clk = ~clk;

  life_automaton_grid_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // row[5:0], column[11:6], cell_in[12], zeros[15:13]
    .in_tuser   (in_tuser),   // mode[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // cell_out[0], zeros[7:1]
    .out_tuser  (out_tuser),  // done_kind[1:0]
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // one generation over the active square; cells outside it neither change
  // nor count as neighbors; returns whether any active cell changed
  function automatic bit evolve_once(int side);
    bit changed;
    int nb;
    int rr;
    int cc;
    int at;
    changed = 1'b0;
    for (int r = 0; r < side; r++) begin
      for (int c = 0; c < side; c++) begin
        nb = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < side && cc < side) begin
              nb += life_grid[rr * SIDE_LIMIT + cc];
            end
          end
        end
        at = r * SIDE_LIMIT + c;
        if (life_grid[at]) begin
          life_next[at] = (nb >= LIVE_MIN_NEIGHBORS) && (nb <= LIVE_MAX_NEIGHBORS);
        end else begin
          life_next[at] = (nb == BIRTH_NEIGHBORS);
        end
      end
    end
    for (int r = 0; r < side; r++) begin
      for (int c = 0; c < side; c++) begin
        at = r * SIDE_LIMIT + c;
        if (life_grid[at] != life_next[at]) begin
          changed = 1'b1;
        end
        life_grid[at] = life_next[at];
      end
    end
    return changed;
  endfunction

  // applies one command to the local grid and returns its answer
  function automatic cell_answer_t predict_command(
      input logic [lage_pkg::MODE_W-1:0] mode,
      input logic [lage_pkg::ROW_W-1:0]  row,
      input logic [lage_pkg::COL_W-1:0]  col,
      input logic                        cell_in);
    cell_answer_t ans;
    int side;
    int at;
    at = int'(row) * SIDE_LIMIT + int'(col);
    ans.cell_val = 1'b0;
    if (mode == lage_pkg::CMD_WRITE) begin
      life_grid[at] = cell_in;
      ans.kind = lage_pkg::CMD_WRITE;
      write_count++;
    end else if (mode == lage_pkg::CMD_RUN) begin
      // side saturates at the grid size
      side = (int'(side_reg) > SIDE_LIMIT) ? SIDE_LIMIT : int'(side_reg);
      // a stable grid ends the run early, with the same outcome
      for (int g = 0; g < int'(gens_reg); g++) begin
        if (!evolve_once(side)) begin
          break;
        end
      end
      ans.kind = lage_pkg::CMD_RUN;
      run_count++;
    end else begin
      ans.cell_val = life_grid[at];
      ans.kind = lage_pkg::CMD_READ;
      read_count++;
      if (mode == CMD_READ_HIGH) begin
        high_read_count++;
      end
    end
    return ans;
  endfunction

  // offer one command, with random gaps before it, until the block takes it
  task automatic send_command(input logic [lage_pkg::MODE_W-1:0] mode,
                              input logic [lage_pkg::ROW_W-1:0]  row,
                              input logic [lage_pkg::COL_W-1:0]  col,
                              input logic                        cell_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= lage_pkg::IN_DATA_W'({cell_in, col, row});
    do @(posedge clk); while (!in_tready);
    pending_answers.push_back(predict_command(mode, row, col, cell_in));
  endtask

  // sender pauses until every answer is back, then the block settles
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic set_register(input lage_pkg::cfg_reg_t idx,
                              input logic [lage_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      lage_pkg::REG_GRID_SIDE: side_reg = value[lage_pkg::GRID_SIDE_W-1:0];
      lage_pkg::REG_GEN_COUNT: gens_reg = value[lage_pkg::GEN_COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic reconfigure(input logic [lage_pkg::GRID_SIDE_W-1:0] side,
                             input logic [lage_pkg::GEN_COUNT_W-1:0] gens);
    wait_for_idle();
    set_register(lage_pkg::REG_GRID_SIDE, lage_pkg::CFG_DATA_W'(side));
    set_register(lage_pkg::REG_GEN_COUNT, gens);
    setting_count++;
  endtask

  // corners of the full grid, cleared state after reset, mode 3 read
  task automatic test_cell_access();
    send_command(lage_pkg::CMD_READ, 6'd0, 6'd0, 1'b1);
    send_command(lage_pkg::CMD_WRITE, 6'd0, 6'd0, 1'b1);
    send_command(lage_pkg::CMD_WRITE, 6'd63, 6'd63, 1'b1);
    send_command(CMD_READ_HIGH, 6'd63, 6'd63, 1'b0);
    send_command(lage_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
  endtask

  // birth in a corner and death of a lone cell, reset settings (side 64, one gen)
  task automatic test_rule_patterns();
    send_command(lage_pkg::CMD_WRITE, 6'd0, 6'd1, 1'b1);
    send_command(lage_pkg::CMD_WRITE, 6'd1, 6'd0, 1'b1);
    send_command(lage_pkg::CMD_RUN, 6'd0, 6'd0, 1'b0);
    send_command(lage_pkg::CMD_READ, 6'd1, 6'd1, 1'b0);
    send_command(lage_pkg::CMD_READ, 6'd63, 6'd63, 1'b0);
  endtask

  // register extremes, cells outside the active square, tiny and oversized sides
  task automatic test_register_extremes();
    // zero generations: nothing moves
    reconfigure(7'd4, 16'd0);
    send_command(lage_pkg::CMD_RUN, 6'd0, 6'd0, 1'b0);
    send_command(lage_pkg::CMD_READ, 6'd1, 6'd1, 1'b0);
    // a line just past the edge would give birth inside if it were counted
    reconfigure(7'd4, 16'd1);
    send_command(lage_pkg::CMD_WRITE, 6'd0, 6'd4, 1'b1);
    send_command(lage_pkg::CMD_WRITE, 6'd1, 6'd4, 1'b1);
    send_command(lage_pkg::CMD_WRITE, 6'd2, 6'd4, 1'b1);
    send_command(lage_pkg::CMD_RUN, 6'd0, 6'd0, 1'b0);
    send_command(lage_pkg::CMD_READ, 6'd1, 6'd3, 1'b0);
    send_command(lage_pkg::CMD_READ, 6'd1, 6'd4, 1'b0);
    // empty active square with the largest count
    reconfigure(7'd0, 16'hffff);
    send_command(lage_pkg::CMD_RUN, 6'd0, 6'd0, 1'b0);
    // side 2: two diagonal cells die, then the grid is stable
    reconfigure(7'd2, 16'hffff);
    send_command(lage_pkg::CMD_WRITE, 6'd1, 6'd1, 1'b0);
    send_command(lage_pkg::CMD_WRITE, 6'd0, 6'd0, 1'b0);
    send_command(lage_pkg::CMD_RUN, 6'd0, 6'd0, 1'b0);
    send_command(lage_pkg::CMD_READ, 6'd0, 6'd1, 1'b0);
    // single active cell has no neighbors and dies
    reconfigure(7'd1, 16'hffff);
    send_command(lage_pkg::CMD_WRITE, 6'd0, 6'd0, 1'b1);
    send_command(lage_pkg::CMD_RUN, 6'd0, 6'd0, 1'b0);
    send_command(lage_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
    // oversized side saturates: the line at column 4 now blinks
    reconfigure(7'd127, 16'd3);
    send_command(lage_pkg::CMD_RUN, 6'd0, 6'd0, 1'b0);
    send_command(lage_pkg::CMD_READ, 6'd1, 6'd3, 1'b0);
  endtask

  // receiver holds off while commands keep coming, so the input stalls
  task automatic test_backpressure_fill();
    wait_for_idle();
    hold_request = HOLD_OFF_LEN;
    for (int i = 0; i < 6; i++) begin
      send_command(($urandom_range(1) != 0) ? lage_pkg::CMD_READ : lage_pkg::CMD_WRITE,
                   6'($urandom_range(7)), 6'($urandom_range(7)), 1'($urandom_range(1)));
    end
    wait_for_idle();
  endtask

  // mostly seeding and reading inside the active square, with runs between
  task automatic test_random_traffic(input logic [lage_pkg::GRID_SIDE_W-1:0] side,
                                     input logic [lage_pkg::GEN_COUNT_W-1:0] gens,
                                     input int count);
    int active;
    int pick;
    logic [lage_pkg::MODE_W-1:0] mode;
    logic [lage_pkg::ROW_W-1:0]  row;
    logic [lage_pkg::COL_W-1:0]  col;
    reconfigure(side, gens);
    active = (int'(side) > SIDE_LIMIT) ? SIDE_LIMIT : int'(side);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        mode = lage_pkg::CMD_WRITE;
      end else if (pick < 80) begin
        mode = lage_pkg::CMD_READ;
      end else if (pick < 93) begin
        mode = lage_pkg::CMD_RUN;
      end else begin
        mode = CMD_READ_HIGH;
      end
      if (active > 0 && $urandom_range(99) < 80) begin
        row = lage_pkg::ROW_W'($urandom_range(active - 1));
        col = lage_pkg::COL_W'($urandom_range(active - 1));
      end else begin
        row = lage_pkg::ROW_W'($urandom_range(SIDE_LIMIT - 1));
        col = lage_pkg::COL_W'($urandom_range(SIDE_LIMIT - 1));
      end
      send_command(mode, row, col, 1'($urandom_range(99) < 65));
    end
  endtask

  // result side: random ready, long hold-off on request, compare each transfer
  initial begin : result_sink
    int hold_left;
    cell_answer_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: result with nothing pending: expected none, got tdata %0h tuser %0d",
                   $time, out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          want = pending_answers.pop_front();
          if (out_tdata != lage_pkg::OUT_DATA_W'(want.cell_val)) begin
            $display("%0t: cell_out mismatch: expected tdata %0h, got %0h",
                     $time, lage_pkg::OUT_DATA_W'(want.cell_val), out_tdata);
            mismatch_count++;
          end
          if (out_tuser != want.kind) begin
            $display("%0t: done_kind mismatch: expected %0d, got %0d",
                     $time, want.kind, out_tuser);
            mismatch_count++;
          end
        end
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ends the run when neither channel moves for too long
  initial begin : stall_watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("life_automaton_grid_engine regression: fail");
    $finish;
  end

  initial begin : sequencer
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sender gaps light, receiver stalls heavy
    send_idle_pct = 33;
    recv_idle_pct = 70;
    test_cell_access();
    test_rule_patterns();
    test_register_extremes();
    test_random_traffic(7'd8, 16'd3, 36);

    // the other way round
    send_idle_pct = 70;
    recv_idle_pct = 33;
    test_backpressure_fill();
    test_random_traffic(7'd5, 16'd40, 34);

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(7'd16, 16'd2, 28);
    test_random_traffic(7'd64, 16'd1, 8);
    wait_for_idle();

    $display("covered %0d cell writes, %0d reads (%0d as mode 3), %0d generation runs",
             write_count, read_count, high_read_count, run_count);
    $display("over %0d register settings, sides 0 to 127, counts 0 to 65535", setting_count);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("life_automaton_grid_engine regression: pass");
    end else begin
      $display("life_automaton_grid_engine regression: fail");
    end
    $finish;
  end

endmodule
